// ===== src/sbet_pkg.sv =====
// ----------------------------------------------------------------------------
// sbet_pkg : shared constants for the surface bin extremum tracker
// Field widths, item mode codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sbet_pkg;

   localparam int DATA_W      = 32;  // Q16.16 coordinates and lengths
   localparam int BIN_FIELD_W = 6;   // read bin and highest bin fields
   localparam int CSR_IDX_W   = 3;

   localparam int DEF_BINS_A  = 64;
   localparam int DEF_BINS_B  = 64;

   // item modes
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_A    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_B    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_AXIS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INWARD       = 3'd4;

   // register reset values
   localparam logic [DATA_W-1:0] RST_BIN_WIDTH    = 32'd65536;
   localparam logic [DATA_W-1:0] RST_BOX_LEN_A    = 32'd2097152;
   localparam logic [DATA_W-1:0] RST_BOX_LEN_B    = 32'd2097152;
   localparam logic [DATA_W-1:0] RST_BOX_LEN_AXIS = 32'd2097152;
   localparam logic              RST_INWARD       = 1'b0;

endpackage

`default_nettype wire

// ===== src/surface_bin_extremum_tracker.sv =====
// ----------------------------------------------------------------------------
// surface_bin_extremum_tracker : per-bin lower/upper surface tracker
// Bins particle positions in the plane and keeps the surface extremes per bin.
// ----------------------------------------------------------------------------
// Usage
//   req_ beat, mode add: a particle (pos_a, pos_b, pos_axis) is binned by
//   bin_width and folded into its bin and into up to three periodic images
//   that land in the partial last bin row. No rsp_ beat results.
//   req_ beat, mode read: returns one bin (read_bin_a, read_bin_b) on rsp_
//   and marks both of its surfaces unused.
//   csr_ writes take effect at once; write only while the block is idle.
// Sequence (QW = clog2 of the larger bin count, 6 by default)
//   add : up to four divides of QW quotient bits each on the shared
//         shift-subtract divider, then a fetch and a write per bin update
//         (0 to 4) in the bin store.
//   read: the bin is fetched from the store, then its result is registered.
//   One item at a time; req_ready is high only while idle. A finished read
//   sits in the output register, so the next item is taken while it waits;
//   a later read holds in its last step until that register is free.
// Reset: a clearing pass over all BINS_A*BINS_B bins wipes the used flags, with
//   req_ready low throughout. Registers return to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module surface_bin_extremum_tracker
   import sbet_pkg::*;
#(
   parameter int BINS_A = DEF_BINS_A,
   parameter int BINS_B = DEF_BINS_B
) (
   input  wire                    clock,
   input  wire                    reset,

   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    req_mode,
   input  wire  [DATA_W-1:0]      req_pos_a,
   input  wire  [DATA_W-1:0]      req_pos_b,
   input  wire  [DATA_W-1:0]      req_pos_axis,
   input  wire  [BIN_FIELD_W-1:0] req_read_bin_a,
   input  wire  [BIN_FIELD_W-1:0] req_read_bin_b,

   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [DATA_W-1:0]      rsp_lower_value,
   output logic                   rsp_lower_valid,
   output logic [DATA_W-1:0]      rsp_upper_value,
   output logic                   rsp_upper_valid,
   output logic [BIN_FIELD_W-1:0] rsp_highest_a,
   output logic [BIN_FIELD_W-1:0] rsp_highest_b,

   input  wire                    csr_we,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [DATA_W-1:0]      csr_wdata
);

   localparam int NB    = BINS_A * BINS_B;
   localparam int AW    = $clog2(NB);
   localparam int QAW   = $clog2(BINS_A);
   localparam int QBW   = $clog2(BINS_B);
   localparam int QW    = (QAW > QBW) ? QAW : QBW;  // quotient bits worth computing
   localparam int LW    = DATA_W + QW;              // bins * width
   localparam int CW    = $clog2(QW + 1);
   localparam int ACC_W = 2 * DATA_W;
   localparam int DSH   = DATA_W - QW;

   localparam logic [AW-1:0] BINS_B_AW = AW'(BINS_B);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NB - 1);
   localparam logic [LW-1:0] BINS_A_LW = LW'(BINS_A);
   localparam logic [LW-1:0] BINS_B_LW = LW'(BINS_B);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV_LOAD,
      ST_DIV,
      ST_PT_SEL,
      ST_PT_RD,
      ST_PT_WR
   } state_type;

   // divide operands, in the order they are worked
   typedef enum logic [1:0] {
      OP_POS_A,
      OP_POS_B,
      OP_LEN_A,
      OP_LEN_B
   } div_op_type;

   // bin updates: the particle, then its images
   typedef enum logic [1:0] {
      PT_BASE,
      PT_IMG_A,
      PT_IMG_B,
      PT_IMG_AB
   } point_type;

   // configuration
   logic [DATA_W-1:0] bin_width_ff, box_len_a_ff, box_len_b_ff, box_len_axis_ff;
   logic              inward_ff;

   // sequencer and item registers
   state_type         state_ff, state_in;
   div_op_type        op_ff, op_in;
   point_type         pt_ff, pt_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              mode_ff, mode_in;
   logic [DATA_W-1:0] pa_ff, pa_in, pb_ff, pb_in, z_ff, z_in;
   logic [BIN_FIELD_W-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic              rd_inr_ff, rd_inr_in;
   logic [LW-1:0]     lim_a_ff, lim_a_in, lim_b_ff, lim_b_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [QW-1:0]     qa_ff, qa_in, qb_ff, qb_in, qla_ff, qla_in, qlb_ff, qlb_in;
   logic [DATA_W-1:0] rla_ff, rla_in, rlb_ff, rlb_in;
   logic              inr_a_ff, inr_a_in, inr_b_ff, inr_b_in;
   logic              inr_la_ff, inr_la_in, inr_lb_ff, inr_lb_in;
   logic [QAW-1:0]    bin_a_ff, bin_a_in, max_a_ff, max_a_in;
   logic [QBW-1:0]    bin_b_ff, bin_b_in, max_b_ff, max_b_in;
   logic [AW-1:0]     addr_ff, addr_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_lower_value_ff, rsp_lower_value_in;
   logic [DATA_W-1:0] rsp_upper_value_ff, rsp_upper_value_in;
   logic              rsp_lower_valid_ff, rsp_lower_valid_in;
   logic              rsp_upper_valid_ff, rsp_upper_valid_in;
   logic [BIN_FIELD_W-1:0] rsp_highest_a_ff, rsp_highest_a_in;
   logic [BIN_FIELD_W-1:0] rsp_highest_b_ff, rsp_highest_b_in;

   // bin store
   logic [DATA_W-1:0] lower_mem [NB];
   logic [DATA_W-1:0] upper_mem [NB];
   logic [1:0]        used_mem  [NB];   // {lower used, upper used}
   logic [DATA_W-1:0] lo_rd_ff, up_rd_ff;
   logic [1:0]        used_rd_ff;
   logic              lo_we, up_we, used_we;
   logic [1:0]        used_wdata;

   // combinational helpers
   logic [DATA_W-1:0] weff;
   logic [DATA_W-1:0] div_dividend;
   logic [LW-1:0]     div_limit;
   logic              div_inr;
   logic [DATA_W:0]   div_t, div_t2;
   logic              div_ge;
   logic [ACC_W-1:0]  acc_step;
   logic              hit_a, hit_b;
   logic              pt_en;
   logic [QAW-1:0]    pt_a;
   logic [QBW-1:0]    pt_b;
   logic [DATA_W-1:0] lfill, ufill, lv, uv;
   logic              lu, uu, low_half, take_lo, take_up, out_free;

   assign weff = (bin_width_ff == '0) ? DATA_W'(1) : bin_width_ff;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff    <= RST_BIN_WIDTH;
         box_len_a_ff    <= RST_BOX_LEN_A;
         box_len_b_ff    <= RST_BOX_LEN_B;
         box_len_axis_ff <= RST_BOX_LEN_AXIS;
         inward_ff       <= RST_INWARD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIN_WIDTH:    bin_width_ff    <= csr_wdata;
            CSR_BOX_LEN_A:    box_len_a_ff    <= csr_wdata;
            CSR_BOX_LEN_B:    box_len_b_ff    <= csr_wdata;
            CSR_BOX_LEN_AXIS: box_len_axis_ff <= csr_wdata;
            CSR_INWARD:       inward_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---- shared divider: one restoring step per cycle
   always_comb begin
      case (op_ff)
         OP_POS_A: begin div_dividend = pa_ff;        div_limit = lim_a_ff; end
         OP_POS_B: begin div_dividend = pb_ff;        div_limit = lim_b_ff; end
         OP_LEN_A: begin div_dividend = box_len_a_ff; div_limit = lim_a_ff; end
         OP_LEN_B: begin div_dividend = box_len_b_ff; div_limit = lim_b_ff; end
         default:  begin div_dividend = pa_ff;        div_limit = lim_a_ff; end
      endcase
      // quotient below the bin count, else the bin is off the store
      div_inr  = {{QW{1'b0}}, div_dividend} < div_limit;
      div_t    = acc_ff[ACC_W-1:DATA_W-1];
      div_ge   = div_t >= {1'b0, weff};
      div_t2   = div_ge ? (div_t - {1'b0, weff}) : div_t;
      acc_step = {div_t2[DATA_W-1:0], acc_ff[DATA_W-2:0], div_ge};
   end

   // ---- image hit: rem(L/w) != 0 and pos + rem(L/w) < w
   always_comb begin
      hit_a = inr_la_ff && (rla_ff != '0)
              && (({1'b0, pa_ff} + {1'b0, rla_ff}) < {1'b0, weff});
      hit_b = inr_lb_ff && (rlb_ff != '0)
              && (({1'b0, pb_ff} + {1'b0, rlb_ff}) < {1'b0, weff});
   end

   always_comb begin
      case (pt_ff)
         PT_BASE: begin
            pt_en = inr_a_ff && inr_b_ff;
            pt_a  = QAW'(qa_ff);  pt_b = QBW'(qb_ff);
         end
         PT_IMG_A: begin
            pt_en = hit_a && inr_b_ff;
            pt_a  = QAW'(qla_ff); pt_b = QBW'(qb_ff);
         end
         PT_IMG_B: begin
            pt_en = hit_b && inr_a_ff;
            pt_a  = QAW'(qa_ff);  pt_b = QBW'(qlb_ff);
         end
         PT_IMG_AB: begin
            pt_en = hit_a && hit_b;
            pt_a  = QAW'(qla_ff); pt_b = QBW'(qlb_ff);
         end
         default: begin
            pt_en = 1'b0;
            pt_a  = QAW'(qa_ff);  pt_b = QBW'(qb_ff);
         end
      endcase
   end

   // ---- surface compare on the fetched bin
   always_comb begin
      lfill    = inward_ff ? box_len_axis_ff : '0;
      ufill    = inward_ff ? '0 : box_len_axis_ff;
      lu       = used_rd_ff[1];
      uu       = used_rd_ff[0];
      lv       = lu ? lo_rd_ff : lfill;
      uv       = uu ? up_rd_ff : ufill;
      low_half = {z_ff, 1'b0} <= {1'b0, box_len_axis_ff};
      if (inward_ff) begin
         take_lo = z_ff <= lv;
         take_up = z_ff >= uv;
      end else begin
         take_lo = low_half && (z_ff >= lv);
         take_up = !low_half && (z_ff <= uv);
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // ---- sequencer next state
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pt_in     = pt_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      z_in      = z_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rd_inr_in = rd_inr_ff;
      lim_a_in  = lim_a_ff;
      lim_b_in  = lim_b_ff;
      acc_in    = acc_ff;
      qa_in     = qa_ff;
      qb_in     = qb_ff;
      qla_in    = qla_ff;
      qlb_in    = qlb_ff;
      rla_in    = rla_ff;
      rlb_in    = rlb_ff;
      inr_a_in  = inr_a_ff;
      inr_b_in  = inr_b_ff;
      inr_la_in = inr_la_ff;
      inr_lb_in = inr_lb_ff;
      bin_a_in  = bin_a_ff;
      bin_b_in  = bin_b_ff;
      max_a_in  = max_a_ff;
      max_b_in  = max_b_ff;
      addr_in   = addr_ff;

      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_lower_value_in = rsp_lower_value_ff;
      rsp_upper_value_in = rsp_upper_value_ff;
      rsp_lower_valid_in = rsp_lower_valid_ff;
      rsp_upper_valid_in = rsp_upper_valid_ff;
      rsp_highest_a_in   = rsp_highest_a_ff;
      rsp_highest_b_in   = rsp_highest_b_ff;

      lo_we      = 1'b0;
      up_we      = 1'b0;
      used_we    = 1'b0;
      used_wdata = 2'b00;

      case (state_ff)
         ST_CLEAR: begin
            used_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               pa_in    = req_pos_a;
               pb_in    = req_pos_b;
               z_in     = req_pos_axis;
               ra_in    = req_read_bin_a;
               rb_in    = req_read_bin_b;
               state_in = ST_SETUP;
            end
         end

         ST_SETUP: begin
            lim_a_in  = LW'(weff) * BINS_A_LW;
            lim_b_in  = LW'(weff) * BINS_B_LW;
            rd_inr_in = (32'(ra_ff) < 32'(BINS_A)) && (32'(rb_ff) < 32'(BINS_B));
            if (mode_ff == MODE_READ) begin
               addr_in  = AW'(AW'(QAW'(ra_ff)) * BINS_B_AW + AW'(QBW'(rb_ff)));
               state_in = ST_PT_RD;
            end else begin
               op_in    = OP_POS_A;
               state_in = ST_DIV_LOAD;
            end
         end

         ST_DIV_LOAD: begin
            case (op_ff)
               OP_POS_A: inr_a_in  = div_inr;
               OP_POS_B: inr_b_in  = div_inr;
               OP_LEN_A: inr_la_in = div_inr;
               OP_LEN_B: inr_lb_in = div_inr;
               default: ;
            endcase
            if (div_inr) begin
               acc_in   = {{DATA_W{1'b0}}, div_dividend} << DSH;
               cnt_in   = CW'(QW - 1);
               state_in = ST_DIV;
            end else begin
               case (op_ff)
                  OP_POS_A: op_in = OP_POS_B;
                  OP_POS_B: op_in = OP_LEN_A;
                  OP_LEN_A: op_in = OP_LEN_B;
                  default:  op_in = OP_POS_A;
               endcase
               if (op_ff == OP_LEN_B) begin
                  pt_in    = PT_BASE;
                  state_in = ST_PT_SEL;
               end
            end
         end

         ST_DIV: begin
            acc_in = acc_step;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1);
            end else begin
               case (op_ff)
                  OP_POS_A: qa_in = acc_step[QW-1:0];
                  OP_POS_B: qb_in = acc_step[QW-1:0];
                  OP_LEN_A: begin
                     qla_in = acc_step[QW-1:0];
                     rla_in = acc_step[ACC_W-1:DATA_W];
                  end
                  OP_LEN_B: begin
                     qlb_in = acc_step[QW-1:0];
                     rlb_in = acc_step[ACC_W-1:DATA_W];
                  end
                  default: ;
               endcase
               case (op_ff)
                  OP_POS_A: op_in = OP_POS_B;
                  OP_POS_B: op_in = OP_LEN_A;
                  OP_LEN_A: op_in = OP_LEN_B;
                  default:  op_in = OP_POS_A;
               endcase
               if (op_ff == OP_LEN_B) begin
                  pt_in    = PT_BASE;
                  state_in = ST_PT_SEL;
               end else begin
                  state_in = ST_DIV_LOAD;
               end
            end
         end

         ST_PT_SEL: begin
            if (pt_en) begin
               bin_a_in = pt_a;
               bin_b_in = pt_b;
               addr_in  = AW'(AW'(pt_a) * BINS_B_AW + AW'(pt_b));
               state_in = ST_PT_RD;
            end else if (pt_ff == PT_IMG_AB) begin
               state_in = ST_IDLE;
            end else begin
               case (pt_ff)
                  PT_BASE:  pt_in = PT_IMG_A;
                  PT_IMG_A: pt_in = PT_IMG_B;
                  default:  pt_in = PT_IMG_AB;
               endcase
            end
         end

         ST_PT_RD: begin
            // store read data lands in the fetch registers at this edge
            state_in = ST_PT_WR;
         end

         ST_PT_WR: begin
            if (mode_ff == MODE_READ) begin
               if (out_free) begin
                  used_we            = rd_inr_ff;
                  used_wdata         = 2'b00;
                  rsp_valid_in       = 1'b1;
                  rsp_lower_valid_in = rd_inr_ff && lu;
                  rsp_upper_valid_in = rd_inr_ff && uu;
                  rsp_lower_value_in = (rd_inr_ff && lu) ? lo_rd_ff : lfill;
                  rsp_upper_value_in = (rd_inr_ff && uu) ? up_rd_ff : ufill;
                  rsp_highest_a_in   = BIN_FIELD_W'(max_a_ff);
                  rsp_highest_b_in   = BIN_FIELD_W'(max_b_ff);
                  state_in           = ST_IDLE;
               end
            end else begin
               lo_we      = take_lo;
               up_we      = take_up;
               used_we    = 1'b1;
               used_wdata = {lu | take_lo, uu | take_up};
               if (bin_a_ff > max_a_ff) max_a_in = bin_a_ff;
               if (bin_b_ff > max_b_ff) max_b_in = bin_b_ff;
               if (pt_ff == PT_IMG_AB) begin
                  state_in = ST_IDLE;
               end else begin
                  case (pt_ff)
                     PT_BASE:  pt_in = PT_IMG_A;
                     PT_IMG_A: pt_in = PT_IMG_B;
                     default:  pt_in = PT_IMG_AB;
                  endcase
                  state_in = ST_PT_SEL;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---- sequencer registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_POS_A;
         pt_ff        <= PT_BASE;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         max_a_ff     <= '0;
         max_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pt_ff        <= pt_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         max_a_ff     <= max_a_in;
         max_b_ff     <= max_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff            <= mode_in;
      pa_ff              <= pa_in;
      pb_ff              <= pb_in;
      z_ff               <= z_in;
      ra_ff              <= ra_in;
      rb_ff              <= rb_in;
      rd_inr_ff          <= rd_inr_in;
      lim_a_ff           <= lim_a_in;
      lim_b_ff           <= lim_b_in;
      acc_ff             <= acc_in;
      qa_ff              <= qa_in;
      qb_ff              <= qb_in;
      qla_ff             <= qla_in;
      qlb_ff             <= qlb_in;
      rla_ff             <= rla_in;
      rlb_ff             <= rlb_in;
      inr_a_ff           <= inr_a_in;
      inr_b_ff           <= inr_b_in;
      inr_la_ff          <= inr_la_in;
      inr_lb_ff          <= inr_lb_in;
      bin_a_ff           <= bin_a_in;
      bin_b_ff           <= bin_b_in;
      rsp_lower_value_ff <= rsp_lower_value_in;
      rsp_upper_value_ff <= rsp_upper_value_in;
      rsp_lower_valid_ff <= rsp_lower_valid_in;
      rsp_upper_valid_ff <= rsp_upper_valid_in;
      rsp_highest_a_ff   <= rsp_highest_a_in;
      rsp_highest_b_ff   <= rsp_highest_b_in;
   end

   // ---- bin store, one address per cycle, registered read
   always_ff @(posedge clock) begin
      if (lo_we) lower_mem[addr_ff] <= z_ff;
      lo_rd_ff <= lower_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (up_we) upper_mem[addr_ff] <= z_ff;
      up_rd_ff <= upper_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[addr_ff] <= used_wdata;
      used_rd_ff <= used_mem[addr_ff];
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lower_value = rsp_lower_value_ff;
   assign rsp_lower_valid = rsp_lower_valid_ff;
   assign rsp_upper_value = rsp_upper_value_ff;
   assign rsp_upper_valid = rsp_upper_valid_ff;
   assign rsp_highest_a   = rsp_highest_a_ff;
   assign rsp_highest_b   = rsp_highest_b_ff;

`ifndef SYNTHESIS
   // partial remainder stays below the divisor while dividing
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (acc_ff[ACC_W-1:DATA_W] < weff))
      else $error("divider remainder out of bound");

   // an add never addresses past the store
   a_pt_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PT_RD && mode_ff == MODE_ADD) |-> (32'(addr_ff) < 32'(NB)))
      else $error("bin address beyond store");

   // highest bin indexes only ever hold bins inside the store
   a_max_range: assert property (@(posedge clock) disable iff (reset)
      (32'(max_a_ff) < 32'(BINS_A)) && (32'(max_b_ff) < 32'(BINS_B)))
      else $error("highest bin beyond store");

   // a result beat only follows the last step of a read item
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PT_WR && mode_ff == MODE_READ))
      else $error("result without read item");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for surface_bin_extremum_tracker
// Drives particle adds and bin reads over the req_ channel and predicts every
// rsp_ beat from a local model of the bin store, the used flags and the
// highest-bin trackers. The run walks through several register settings.
// ----------------------------------------------------------------------------

module testbench;
   import sbet_pkg::*;

   localparam int BINS_A        = DEF_BINS_A;
   localparam int BINS_B        = DEF_BINS_B;
   localparam int NBINS         = BINS_A * BINS_B;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 800;   // long rsp_ hold-off, fills the block

   typedef struct {
      logic                   mode;
      logic [DATA_W-1:0]      pos_a;
      logic [DATA_W-1:0]      pos_b;
      logic [DATA_W-1:0]      pos_axis;
      logic [BIN_FIELD_W-1:0] bin_a;
      logic [BIN_FIELD_W-1:0] bin_b;
   } req_item_t;

   typedef struct {
      logic [DATA_W-1:0]      lower_value;
      logic                   lower_valid;
      logic [DATA_W-1:0]      upper_value;
      logic                   upper_valid;
      logic [BIN_FIELD_W-1:0] highest_a;
      logic [BIN_FIELD_W-1:0] highest_b;
   } bin_report_t;

   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} rdy_style_e;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_mode       = MODE_ADD;
   logic [DATA_W-1:0]      req_pos_a      = '0;
   logic [DATA_W-1:0]      req_pos_b      = '0;
   logic [DATA_W-1:0]      req_pos_axis   = '0;
   logic [BIN_FIELD_W-1:0] req_read_bin_a = '0;
   logic [BIN_FIELD_W-1:0] req_read_bin_b = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [DATA_W-1:0]      rsp_lower_value;
   logic                   rsp_lower_valid;
   logic [DATA_W-1:0]      rsp_upper_value;
   logic                   rsp_upper_valid;
   logic [BIN_FIELD_W-1:0] rsp_highest_a;
   logic [BIN_FIELD_W-1:0] rsp_highest_b;
   logic                   csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index      = '0;
   logic [DATA_W-1:0]      csr_wdata      = '0;

   surface_bin_extremum_tracker dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pos_a       (req_pos_a),
      .req_pos_b       (req_pos_b),
      .req_pos_axis    (req_pos_axis),
      .req_read_bin_a  (req_read_bin_a),
      .req_read_bin_b  (req_read_bin_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lower_value (rsp_lower_value),
      .rsp_lower_valid (rsp_lower_valid),
      .rsp_upper_value (rsp_upper_value),
      .rsp_upper_valid (rsp_upper_valid),
      .rsp_highest_a   (rsp_highest_a),
      .rsp_highest_b   (rsp_highest_b),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Bin store model: register copies, surfaces, used flags, highest bins
   // ------------------------------------------------------------------------
   logic [DATA_W-1:0] cfg_width    = RST_BIN_WIDTH;
   logic [DATA_W-1:0] cfg_len_a    = RST_BOX_LEN_A;
   logic [DATA_W-1:0] cfg_len_b    = RST_BOX_LEN_B;
   logic [DATA_W-1:0] cfg_len_axis = RST_BOX_LEN_AXIS;
   logic              cfg_inward   = RST_INWARD;

   logic [DATA_W-1:0] lower_z [NBINS];
   logic [DATA_W-1:0] upper_z [NBINS];
   bit                lower_hit [NBINS];
   bit                upper_hit [NBINS];
   int unsigned       peak_a = 0;
   int unsigned       peak_b = 0;

   bin_report_t due_reports [$];   // one per accepted read, oldest first
   req_item_t   req_backlog [$];   // beats waiting for the driver
   int          error_count = 0;
   int          reads_seen  = 0;

   // zero width counts as one LSB
   function automatic logic [63:0] eff_width();
      return (cfg_width == '0) ? 64'd1 : {32'd0, cfg_width};
   endfunction

   function automatic logic [DATA_W-1:0] lower_fill();
      return cfg_inward ? cfg_len_axis : '0;
   endfunction

   function automatic logic [DATA_W-1:0] upper_fill();
      return cfg_inward ? '0 : cfg_len_axis;
   endfunction

   // periodic image lands strictly inside the partial last row
   function automatic bit in_last_row(logic [63:0] img, logic [DATA_W-1:0] len);
      logic [63:0] w;
      logic [63:0] lo;
      logic [63:0] hi;
      w  = eff_width();
      lo = ({32'd0, len} / w) * w;
      hi = (lo != {32'd0, len}) ? lo + w : lo;
      return (img > lo) && (img < hi);
   endfunction

   function automatic void deposit(logic [63:0] ba, logic [63:0] bb,
                                   logic [DATA_W-1:0] z);
      int                idx;
      logic [DATA_W-1:0] lv;
      logic [DATA_W-1:0] uv;
      if (ba >= BINS_A || bb >= BINS_B) return;
      if (ba > peak_a) peak_a = ba;
      if (bb > peak_b) peak_b = bb;
      idx = int'(ba) * BINS_B + int'(bb);
      lv  = lower_hit[idx] ? lower_z[idx] : lower_fill();
      uv  = upper_hit[idx] ? upper_z[idx] : upper_fill();
      if (!cfg_inward) begin
         if ({z, 1'b0} <= {1'b0, cfg_len_axis}) begin
            if (z >= lv) begin
               lower_z[idx]   = z;
               lower_hit[idx] = 1'b1;
            end
         end else if (z <= uv) begin
            upper_z[idx]   = z;
            upper_hit[idx] = 1'b1;
         end
      end else begin
         if (z <= lv) begin
            lower_z[idx]   = z;
            lower_hit[idx] = 1'b1;
         end
         if (z >= uv) begin
            upper_z[idx]   = z;
            upper_hit[idx] = 1'b1;
         end
      end
   endfunction

   // one accepted req_ beat: fold a particle in, or queue the bin report
   function automatic void apply_beat(req_item_t it);
      logic [63:0] w;
      logic [63:0] pa;
      logic [63:0] pb;
      logic [63:0] ia;
      logic [63:0] ib;
      bit          ha;
      bit          hb;
      int          idx;
      bin_report_t rep;
      if (it.mode == MODE_ADD) begin
         w  = eff_width();
         pa = {32'd0, it.pos_a};
         pb = {32'd0, it.pos_b};
         ia = pa + cfg_len_a;
         ib = pb + cfg_len_b;
         ha = in_last_row(ia, cfg_len_a);
         hb = in_last_row(ib, cfg_len_b);
         deposit(pa / w, pb / w, it.pos_axis);
         if (ha) deposit(ia / w, pb / w, it.pos_axis);
         if (hb) deposit(pa / w, ib / w, it.pos_axis);
         if (ha && hb) deposit(ia / w, ib / w, it.pos_axis);
      end else begin
         idx             = int'(it.bin_a) * BINS_B + int'(it.bin_b);
         rep.lower_valid = lower_hit[idx];
         rep.upper_valid = upper_hit[idx];
         rep.lower_value = lower_hit[idx] ? lower_z[idx] : lower_fill();
         rep.upper_value = upper_hit[idx] ? upper_z[idx] : upper_fill();
         rep.highest_a   = peak_a[BIN_FIELD_W-1:0];
         rep.highest_b   = peak_b[BIN_FIELD_W-1:0];
         lower_hit[idx]  = 1'b0;
         upper_hit[idx]  = 1'b0;
         due_reports.push_back(rep);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Item makers. Reads only touch the tracked bins (k,k) and (k,63-k); the
   // prefill writes both surfaces of each of them before any read.
   // ------------------------------------------------------------------------
   req_item_t last_add;
   bit        last_add_set = 1'b0;

   function automatic req_item_t add_item(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                          logic [DATA_W-1:0] z);
      req_item_t it;
      it.mode     = MODE_ADD;
      it.pos_a    = a;
      it.pos_b    = b;
      it.pos_axis = z;
      it.bin_a    = $urandom;
      it.bin_b    = $urandom;
      return it;
   endfunction

   function automatic req_item_t read_item(int ra, int rb);
      req_item_t it;
      it.mode     = MODE_READ;
      it.pos_a    = $urandom;
      it.pos_b    = $urandom;
      it.pos_axis = $urandom;
      it.bin_a    = ra;
      it.bin_b    = rb;
      return it;
   endfunction

   function automatic req_item_t make_read();
      int k;
      k = $urandom_range(0, 63);
      return read_item(k, $urandom_range(0, 1) ? k : 63 - k);
   endfunction

   function automatic logic [DATA_W-1:0] coord_for_bin(int t);
      logic [63:0] w;
      logic [63:0] v;
      w = eff_width();
      v = 64'(t) * w + $urandom_range(0, 32'(w - 1));
      return (v > 64'hFFFF_FFFF) ? DATA_W'($urandom) : v[DATA_W-1:0];
   endfunction

   // coordinate whose periodic image falls in the partial row, if there is one
   function automatic logic [DATA_W-1:0] image_coord(logic [DATA_W-1:0] len, int t);
      logic [63:0] w;
      logic [63:0] lo;
      w  = eff_width();
      lo = ({32'd0, len} / w) * w;
      if (lo == {32'd0, len}) return coord_for_bin(t);
      return $urandom_range(0, 32'(lo + w - len - 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_height();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return cfg_len_axis;
      if (roll < 35) return (cfg_len_axis >> 1) + $urandom_range(0, 2) - 1;
      if (roll < 55) return $urandom;
      return $urandom_range(0, cfg_len_axis);
   endfunction

   function automatic req_item_t make_add();
      int        roll;
      int        k;
      req_item_t it;
      roll = $urandom_range(0, 99);
      if (roll < 8 && last_add_set) return last_add;   // same point again: ties
      if (roll < 50) begin
         k  = $urandom_range(0, 63);
         it = add_item(coord_for_bin(k),
                       coord_for_bin($urandom_range(0, 1) ? k : 63 - k), pick_height());
      end else if (roll < 68) begin
         it = add_item($urandom_range(0, 1) ? image_coord(cfg_len_a, 5)
                                            : coord_for_bin($urandom_range(0, 63)),
                       $urandom_range(0, 1) ? image_coord(cfg_len_b, 9)
                                            : coord_for_bin($urandom_range(0, 63)),
                       pick_height());
      end else if (roll < 78) begin
         it = add_item($urandom, $urandom, pick_height());
      end else begin
         it = add_item(coord_for_bin($urandom_range(0, 70)),
                       coord_for_bin($urandom_range(0, 70)), pick_height());
      end
      last_add     = it;
      last_add_set = 1'b1;
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts of beats with random gaps, payload held until accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic      offer;
      int        burst_left;
      int        gap_left;
      req_item_t on_wire;
      offer = req_valid;
      if (reset) begin
         offer      = 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_beat(on_wire);
            offer = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() != 0) begin
               on_wire = req_backlog.pop_front();
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               offer          = 1'b1;
               req_mode       <= on_wire.mode;
               req_pos_a      <= on_wire.pos_a;
               req_pos_b      <= on_wire.pos_b;
               req_pos_axis   <= on_wire.pos_axis;
               req_read_bin_a <= on_wire.bin_a;
               req_read_bin_b <= on_wire.bin_b;
            end
         end
      end
      req_valid <= offer;
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each rsp_ beat against the oldest predicted report and
   // picks the next rsp_ready from a changing stall pattern
   // ------------------------------------------------------------------------
   logic rsp_hold = 1'b0;

   task automatic note_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : watch_rsp
      bin_report_t want;
      logic        take;
      int          stall_tick;
      rdy_style_e  stall_style;
      if (reset) begin
         stall_tick  = 0;
         stall_style = RDY_ALWAYS;
         rsp_ready   <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               note_mismatch("rsp beat with no read outstanding");
            end else begin
               want = due_reports.pop_front();
               reads_seen++;
               if (rsp_lower_value !== want.lower_value)
                  note_mismatch($sformatf("read %0d lower_value %h, expected %h",
                                          reads_seen, rsp_lower_value, want.lower_value));
               if (rsp_lower_valid !== want.lower_valid)
                  note_mismatch($sformatf("read %0d lower_valid %b, expected %b",
                                          reads_seen, rsp_lower_valid, want.lower_valid));
               if (rsp_upper_value !== want.upper_value)
                  note_mismatch($sformatf("read %0d upper_value %h, expected %h",
                                          reads_seen, rsp_upper_value, want.upper_value));
               if (rsp_upper_valid !== want.upper_valid)
                  note_mismatch($sformatf("read %0d upper_valid %b, expected %b",
                                          reads_seen, rsp_upper_valid, want.upper_valid));
               if (rsp_highest_a !== want.highest_a)
                  note_mismatch($sformatf("read %0d highest_a %0d, expected %0d",
                                          reads_seen, rsp_highest_a, want.highest_a));
               if (rsp_highest_b !== want.highest_b)
                  note_mismatch($sformatf("read %0d highest_b %0d, expected %0d",
                                          reads_seen, rsp_highest_b, want.highest_b));
            end
         end
         stall_tick++;
         if (stall_tick % 300 == 0) stall_style = rdy_style_e'($urandom_range(0, 3));
         case (stall_style)
            RDY_ALWAYS: take = 1'b1;
            RDY_COIN:   take = $urandom_range(0, 1);
            RDY_MOSTLY: take = (stall_tick % 8) != 0;
            default:    take = ($urandom_range(0, 5) == 0);
         endcase
         rsp_ready <= take && !rsp_hold;
      end
   end

   // long receiver hold-off, counted here once armed by the stimulus
   bit hold_armed = 1'b0;

   initial begin : long_hold
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL surface_bin_extremum_tracker");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // sender pauses until all beats are in and every report has come back;
   // adds give no beat, so a latency margin follows before any csr write
   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || due_reports.size() != 0)
         @(posedge clock);
      while (!req_ready) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BIN_WIDTH:    cfg_width    = val;
         CSR_BOX_LEN_A:    cfg_len_a    = val;
         CSR_BOX_LEN_B:    cfg_len_b    = val;
         CSR_BOX_LEN_AXIS: cfg_len_axis = val;
         CSR_INWARD:       cfg_inward   = val[0];
         default: ;
      endcase
   endtask

   task automatic start_phase(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] la,
                              input logic [DATA_W-1:0] lb, input logic [DATA_W-1:0] lax,
                              input logic inw);
      settle();
      set_reg(CSR_BIN_WIDTH, w);
      set_reg(CSR_BOX_LEN_A, la);
      set_reg(CSR_BOX_LEN_B, lb);
      set_reg(CSR_BOX_LEN_AXIS, lax);
      set_reg(CSR_INWARD, {{(DATA_W-1){1'b0}}, inw});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random(input int n_items, input int lead_reads);
      for (int i = 0; i < lead_reads; i++) req_backlog.push_back(make_read());
      for (int i = 0; i < n_items; i++)
         req_backlog.push_back(($urandom_range(0, 3) == 0) ? make_read() : make_add());
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // prefill at reset settings: one low and one high point per tracked bin,
      // so both surfaces of every bin that is ever read hold a written value
      for (int k = 0; k < 64; k++) begin
         for (int j = 0; j < 2; j++) begin
            req_backlog.push_back(add_item(coord_for_bin(k),
                                           coord_for_bin(j ? 63 - k : k),
                                           $urandom_range(0, cfg_len_axis >> 1)));
            req_backlog.push_back(add_item(coord_for_bin(k),
                                           coord_for_bin(j ? 63 - k : k),
                                           $urandom_range((cfg_len_axis >> 1) + 1,
                                                          cfg_len_axis)));
         end
      end

      // directed, outward: 1.0 bins, 20.5 box so bin row 20 is partial
      start_phase(32'h0001_0000, 32'h0014_8000, 32'h0014_8000, 32'h0020_0000, 1'b0);
      req_backlog.push_back(add_item(32'h0, 32'h0, 32'h0));              // all images
      req_backlog.push_back(add_item(32'h7FFF, 32'h8000, 32'h0010_0000)); // a image, mid
      req_backlog.push_back(add_item(32'h8000, 32'h7FFF, 32'h0010_0001)); // b image, upper
      req_backlog.push_back(add_item(32'h7FFF, 32'h7FFF, 32'h0020_0000)); // both, box top
      req_backlog.push_back(add_item('1, '1, '1));                        // outside store
      req_backlog.push_back(add_item(32'h003F_0000, 32'h0040_0000, 32'h5_0000));
      req_backlog.push_back(read_item(0, 0));
      req_backlog.push_back(read_item(20, 20));
      req_backlog.push_back(add_item(32'h003F_0001, 32'h003F_FFFF, 32'h8_0000));
      req_backlog.push_back(add_item(32'h003F_0001, 32'h003F_FFFF, 32'h8_0000)); // tie
      req_backlog.push_back(read_item(63, 63));
      req_backlog.push_back(read_item(63, 63));                           // now unused
      req_backlog.push_back(add_item(32'h003F_8000, 32'h003F_8000, 32'h0018_0000));
      req_backlog.push_back(read_item(63, 63));
      req_backlog.push_back(read_item(0, 63));
      req_backlog.push_back(read_item(63, 0));

      // directed, inward with a zero bin width (one LSB per bin)
      start_phase(32'h0, 32'h0014_8000, 32'h0014_8000, 32'd1000, 1'b1);
      req_backlog.push_back(add_item(32'd7, 32'd7, 32'd500));
      req_backlog.push_back(read_item(7, 7));
      req_backlog.push_back(read_item(7, 7));
      req_backlog.push_back(add_item(32'd7, 32'd7, 32'd1000));            // equals fill
      req_backlog.push_back(add_item(32'd7, 32'd7, 32'd1000));
      req_backlog.push_back(add_item(32'd7, 32'd7, 32'd0));
      req_backlog.push_back(read_item(7, 7));
      req_backlog.push_back(add_item(32'd64, 32'd3, 32'd5));              // dropped
      req_backlog.push_back(read_item(3, 60));

      // random: a read-heavy opening while rsp_ is held off backs the block up
      start_phase(32'h0001_0000, 32'h0014_8000, 32'h0021_4000, 32'h0020_0000, 1'b0);
      queue_random(220, 30);
      hold_armed = 1'b1;

      start_phase(32'h0001_0000, 32'h0014_8000, 32'h0021_4000, 32'h0020_0000, 1'b1);
      queue_random(200, 0);

      start_phase(32'h0000_8000, 32'h000A_4CCC, 32'h000A_4CCC, '1, 1'b0);
      queue_random(200, 0);

      start_phase(32'h0, 32'd1, 32'd1, 32'd1, 1'b1);
      queue_random(150, 0);

      start_phase('1, '1, '1, $urandom, 1'b0);
      queue_random(120, 0);

      start_phase(32'h0001_0000, 32'd1, 32'h0003_0001, 32'h0008_0000, 1'b1);
      queue_random(150, 0);

      for (int p = 0; p < 2; p++) begin
         start_phase($urandom_range(32'h4000, 32'h4_0000), $urandom_range(1, 32'h400_0000),
                     $urandom_range(1, 32'h400_0000), $urandom, $urandom_range(0, 1));
         queue_random(130, 0);
      end

      // drain, then a latency margin for any late or stray beat
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_reports.size() != 0)
         note_mismatch($sformatf("%0d reports never arrived", due_reports.size()));
      if (error_count == 0) begin
         $display("PASS surface_bin_extremum_tracker");
      end else begin
         $display("FAIL surface_bin_extremum_tracker");
      end
      $finish;
   end

endmodule

// ===== surface_bin_extremum_tracker.f =====
src/sbet_pkg.sv
src/surface_bin_extremum_tracker.sv
tb/testbench.sv
